// ===== rtl/por_pkg.sv =====
// Shared types and constants for the pulse oximetry ratio estimator.
// No dependencies; imported by the divider and the top level.
package por_pkg;

	localparam int SAMPLE_BITS_DEF   = 18;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int IN_BITS           = 18;
	localparam int GAIN_BITS         = 16;
	localparam int WLEN_BITS         = 10;
	localparam int SAT_BITS          = 7;
	localparam int CFG_INDEX_BITS    = 2;
	localparam int CFG_DATA_BITS     = 16;

	localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd3277;
	localparam logic [WLEN_BITS-1:0] WLEN_RESET = 10'd100;

	localparam logic [CFG_INDEX_BITS-1:0] REG_BASELINE_GAIN = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 2'd1;

	// Saturation line: 110 - 25 R, clamped to 0..100; R limited to 8
	localparam int SAT_OFFSET = 110;
	localparam int SAT_SLOPE  = 25;
	localparam int SAT_MAX    = 100;
	localparam int R_LIMIT    = 8;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== rtl/por_mul.sv =====
// Shared registered multiplier of the estimator datapath.
// No dependencies.
module por_mul #(
	parameter int A_BITS = 35,
	parameter int B_BITS = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [A_BITS-1:0]        a,
	input  logic [B_BITS-1:0]        b,
	output logic [A_BITS+B_BITS-1:0] p
);

	always_ff @(posedge clk) begin
		if (en) begin
			p <= (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);
		end
	end

endmodule

// ===== rtl/por_div.sv =====
// Restoring divider giving floor(num * 2^FB / den), limited to R_LIMIT.
// Depends on por_pkg for the status struct and the ratio limit.
module por_div #(
	parameter int NB = 70,
	parameter int FB = 16,
	parameter int QB = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NB-1:0]         num,
	input  logic [NB-1:0]         den,
	output logic [QB-1:0]         quot,
	output por_pkg::div_status_t  status
);
	import por_pkg::*;

	localparam int WW = NB + 4;
	localparam int SW = $clog2(FB + 3);
	localparam logic [QB-1:0] Q_SAT = QB'(R_LIMIT) << FB;

	logic [WW-1:0] rem_q, div_q;
	logic [QB-1:0] quot_q;
	logic [SW-1:0] step_q;
	logic          run_q, done_q;

	logic          int_phase;
	logic [WW-1:0] trial, diff;
	logic          ge;
	logic          sat;

	assign sat       = WW'(num) >= (WW'(den) << 3);
	assign int_phase = step_q < SW'(3);
	assign trial     = int_phase ? rem_q : (rem_q << 1);
	assign ge        = trial >= div_q;
	assign diff      = trial - div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= '0;
				run_q  <= !sat;
				done_q <= sat;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(FB + 2)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= WW'(num);
			div_q  <= WW'(den) << 2;
			quot_q <= sat ? Q_SAT : '0;
		end else if (run_q) begin
			rem_q  <= ge ? diff : trial;
			quot_q <= {quot_q[QB-2:0], ge};
			// walk the divisor down to its plain value over the integer bits
			if (step_q < SW'(2)) begin
				div_q <= div_q >> 1;
			end
		end
	end

	assign quot        = quot_q;
	assign status.busy = run_q;
	assign status.done = done_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !run_q)
		else $error("divider restarted while running");

	a_quot_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (quot_q <= Q_SAT))
		else $error("ratio above limit");

endmodule

// ===== rtl/pulse_oximetry_ratio_estimator.sv =====
// Pulse oximetry ratio-of-ratios estimator: one result per request. A request that closes a
// window with a usable estimate also runs the cross products through the shared multiplier
// and the ratio through the bit-serial divider before its result is given.
// in_ready is high only in idle; one request is worked on at a time.
// arst_n clears baselines, envelopes, count, held estimate and restores register defaults.
module pulse_oximetry_ratio_estimator #(
	parameter int SAMPLE_BITS   = por_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = por_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [por_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [por_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [por_pkg::IN_BITS-1:0]         red_sample,
	input  logic [por_pkg::IN_BITS-1:0]         infrared_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [por_pkg::SAT_BITS-1:0]        saturation_percent,
	output logic                                estimate_valid,
	output logic                                window_closed
);
	import por_pkg::*;

	localparam int FULL  = SAMPLE_BITS + FRACTION_BITS;
	localparam int WA    = FULL + 1;
	localparam int NCH   = (FULL + GAIN_BITS - 1) / GAIN_BITS;
	localparam int BSH_W = NCH * GAIN_BITS;
	localparam int PW    = WA + GAIN_BITS;
	localparam int ACC_W = WA + BSH_W;
	localparam int CW    = $clog2(NCH) + 1;
	localparam int QB    = FRACTION_BITS + 4;
	localparam int VW    = FRACTION_BITS + 10;
	localparam int EXT_W = (SAMPLE_BITS > IN_BITS) ? SAMPLE_BITS : IN_BITS;

	localparam logic signed [WA-1:0] ENV_MIN = {1'b1, {FULL{1'b0}}};
	localparam logic signed [WA-1:0] ENV_MAX = {1'b0, {FULL{1'b1}}};
	localparam logic [FULL-1:0]      ONE_FIX = FULL'(1) << FRACTION_BITS;

	// sequencer codes
	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_TRK_R_MUL = 4'd1;
	localparam logic [3:0] ST_TRK_R_UPD = 4'd2;
	localparam logic [3:0] ST_TRK_I_MUL = 4'd3;
	localparam logic [3:0] ST_TRK_I_UPD = 4'd4;
	localparam logic [3:0] ST_ENV       = 4'd5;
	localparam logic [3:0] ST_NUM_MUL   = 4'd6;
	localparam logic [3:0] ST_NUM_ACC   = 4'd7;
	localparam logic [3:0] ST_DEN_MUL   = 4'd8;
	localparam logic [3:0] ST_DEN_ACC   = 4'd9;
	localparam logic [3:0] ST_DIV_GO    = 4'd10;
	localparam logic [3:0] ST_DIV       = 4'd11;
	localparam logic [3:0] ST_EST       = 4'd12;
	localparam logic [3:0] ST_OUT       = 4'd13;

	logic [3:0]             state_q;

	// configuration
	logic [GAIN_BITS-1:0]   gain_q;
	logic [WLEN_BITS-1:0]   wlen_q;

	// architectural state
	logic [FULL-1:0]        red_base_q, ir_base_q;
	logic signed [WA-1:0]   r_hi_q, r_lo_q, i_hi_q, i_lo_q;
	logic [WLEN_BITS-1:0]   cnt_q;
	logic [SAT_BITS-1:0]    held_sat_q;
	logic                   held_valid_q;
	logic                   close_q;

	// working registers
	logic [FULL-1:0]        tr_q, ti_q;
	logic [WA-1:0]          rpp_q, ipp_q;
	logic [BSH_W-1:0]       bsh_q;
	logic [ACC_W-1:0]       acc_q, num_q;
	logic [CW-1:0]          kc_q;

	// output register
	logic                   out_valid_q;
	logic [SAT_BITS-1:0]    sat_out_q;
	logic                   est_out_q, closed_out_q;

	// ------------------------------------------------------------------
	// Sample capture: drop bits above SAMPLE_BITS, place at Q.FRACTION_BITS
	// ------------------------------------------------------------------
	logic [EXT_W-1:0] red_ext, ir_ext;
	assign red_ext = EXT_W'(red_sample);
	assign ir_ext  = EXT_W'(infrared_sample);

	// ------------------------------------------------------------------
	// Shared multiplier: baseline gain step, then the cross products in
	// GAIN_BITS-wide chunks, most significant chunk first.
	// ------------------------------------------------------------------
	logic [WA-1:0]        mul_a;
	logic [GAIN_BITS-1:0] mul_b;
	logic                 mul_en;
	logic [PW-1:0]        mul_p;

	por_mul #(
		.A_BITS (WA),
		.B_BITS (GAIN_BITS)
	) u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// ------------------------------------------------------------------
	// Baseline tracking: b + floor(g * (t - b) / 2^16), shared by both
	// channels; the falling case rounds the step up so b never overshoots.
	// ------------------------------------------------------------------
	logic                trk_ir;
	logic [FULL-1:0]     trk_base, trk_tgt, trk_mag, trk_new;
	logic signed [FULL:0] trk_d;
	logic                trk_neg;
	logic [PW:0]         trk_rnd;

	assign trk_ir   = (state_q == ST_TRK_I_MUL) || (state_q == ST_TRK_I_UPD);
	assign trk_base = trk_ir ? ir_base_q : red_base_q;
	assign trk_tgt  = trk_ir ? ti_q : tr_q;
	assign trk_d    = $signed({1'b0, trk_tgt}) - $signed({1'b0, trk_base});
	assign trk_neg  = trk_d[FULL];
	assign trk_mag  = trk_neg ? FULL'(-trk_d) : FULL'(trk_d);
	assign trk_rnd  = {1'b0, mul_p} + {{(PW + 1 - GAIN_BITS){1'b0}}, {GAIN_BITS{1'b1}}};
	assign trk_new  = trk_neg ? (trk_base - FULL'(trk_rnd >> GAIN_BITS))
	                          : (trk_base + FULL'(mul_p >> GAIN_BITS));

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b0;
		unique case (state_q)
			ST_TRK_R_MUL, ST_TRK_I_MUL: begin
				mul_a  = WA'(trk_mag);
				mul_b  = gain_q;
				mul_en = 1'b1;
			end
			ST_NUM_MUL: begin
				mul_a  = rpp_q;
				mul_b  = bsh_q[BSH_W-1 -: GAIN_BITS];
				mul_en = 1'b1;
			end
			ST_DEN_MUL: begin
				mul_a  = ipp_q;
				mul_b  = bsh_q[BSH_W-1 -: GAIN_BITS];
				mul_en = 1'b1;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Envelope update and window close decision
	// ------------------------------------------------------------------
	logic signed [WA-1:0] ac_r, ac_i;
	logic signed [WA-1:0] r_hi_n, r_lo_n, i_hi_n, i_lo_n;
	logic signed [WA:0]   rpp_d, ipp_d;
	logic [WA-1:0]        rpp_c, ipp_c;
	logic [WLEN_BITS-1:0] cnt_n;
	logic                 win_end, est_ok;

	assign ac_r   = $signed({1'b0, tr_q}) - $signed({1'b0, red_base_q});
	assign ac_i   = $signed({1'b0, ti_q}) - $signed({1'b0, ir_base_q});
	assign r_hi_n = (ac_r > r_hi_q) ? ac_r : r_hi_q;
	assign r_lo_n = (ac_r < r_lo_q) ? ac_r : r_lo_q;
	assign i_hi_n = (ac_i > i_hi_q) ? ac_i : i_hi_q;
	assign i_lo_n = (ac_i < i_lo_q) ? ac_i : i_lo_q;

	assign rpp_d  = {r_hi_n[WA-1], r_hi_n} - {r_lo_n[WA-1], r_lo_n};
	assign ipp_d  = {i_hi_n[WA-1], i_hi_n} - {i_lo_n[WA-1], i_lo_n};
	// a negative spread counts as none
	assign rpp_c  = rpp_d[WA] ? '0 : rpp_d[WA-1:0];
	assign ipp_c  = ipp_d[WA] ? '0 : ipp_d[WA-1:0];

	assign cnt_n   = cnt_q + 1'b1;
	assign win_end = cnt_n >= wlen_q;
	assign est_ok  = (red_base_q > ONE_FIX) && (ir_base_q > ONE_FIX) &&
	                 (ipp_c > WA'(ONE_FIX));

	// Horner step over chunks of the baseline operand
	logic [ACC_W-1:0] acc_n;
	assign acc_n = (acc_q << GAIN_BITS) + ACC_W'(mul_p);

	// ------------------------------------------------------------------
	// Ratio divider: R = N / D in Q.FRACTION_BITS, limited to 8
	// ------------------------------------------------------------------
	logic        div_start;
	logic [QB-1:0] div_quot;
	div_status_t div_st;

	assign div_start = (state_q == ST_DIV_GO);

	por_div #(
		.NB (ACC_W),
		.FB (FRACTION_BITS),
		.QB (QB)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (acc_q),
		.quot   (div_quot),
		.status (div_st)
	);

	// ------------------------------------------------------------------
	// Estimate: 110 - 25 R, clamp to 0..100, round half up to whole percent
	// ------------------------------------------------------------------
	logic [VW-1:0]       est_off, est_slope, est_v, est_cap, est_c, est_rnd;
	logic [SAT_BITS-1:0] est_pct;

	assign est_off   = VW'(SAT_OFFSET) << FRACTION_BITS;
	assign est_cap   = VW'(SAT_MAX) << FRACTION_BITS;
	assign est_slope = VW'(div_quot) * VW'(SAT_SLOPE);
	assign est_v     = est_off - est_slope;
	assign est_c     = est_v[VW-1] ? '0 : ((est_v > est_cap) ? est_cap : est_v);
	assign est_rnd   = est_c + (VW'(1) << (FRACTION_BITS - 1));
	assign est_pct   = SAT_BITS'(est_rnd >> FRACTION_BITS);

	// ------------------------------------------------------------------
	// Handshakes
	// ------------------------------------------------------------------
	logic in_fire, out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// ------------------------------------------------------------------
	// Sequencer and state registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			gain_q       <= GAIN_RESET;
			wlen_q       <= WLEN_RESET;
			red_base_q   <= '0;
			ir_base_q    <= '0;
			r_hi_q       <= ENV_MIN;
			r_lo_q       <= ENV_MAX;
			i_hi_q       <= ENV_MIN;
			i_lo_q       <= ENV_MAX;
			cnt_q        <= '0;
			held_sat_q   <= '0;
			held_valid_q <= 1'b0;
			close_q      <= 1'b0;
			kc_q         <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_BASELINE_GAIN: gain_q <= cfg_data[GAIN_BITS-1:0];
					REG_WINDOW_LENGTH: wlen_q <= cfg_data[WLEN_BITS-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_TRK_R_MUL;
					end
				end
				ST_TRK_R_MUL: begin
					// a zero red baseline means unseeded: take both samples as is
					if (red_base_q == '0) begin
						red_base_q <= tr_q;
						ir_base_q  <= ti_q;
						state_q    <= ST_ENV;
					end else begin
						state_q <= ST_TRK_R_UPD;
					end
				end
				ST_TRK_R_UPD: begin
					red_base_q <= trk_new;
					state_q    <= ST_TRK_I_MUL;
				end
				ST_TRK_I_MUL: begin
					state_q <= ST_TRK_I_UPD;
				end
				ST_TRK_I_UPD: begin
					ir_base_q <= trk_new;
					state_q   <= ST_ENV;
				end
				ST_ENV: begin
					if (win_end) begin
						// window over: rearm sentinels whether or not an estimate follows
						close_q <= 1'b1;
						cnt_q   <= '0;
						r_hi_q  <= ENV_MIN;
						r_lo_q  <= ENV_MAX;
						i_hi_q  <= ENV_MIN;
						i_lo_q  <= ENV_MAX;
						kc_q    <= CW'(NCH - 1);
						state_q <= est_ok ? ST_NUM_MUL : ST_OUT;
					end else begin
						close_q <= 1'b0;
						cnt_q   <= cnt_n;
						r_hi_q  <= r_hi_n;
						r_lo_q  <= r_lo_n;
						i_hi_q  <= i_hi_n;
						i_lo_q  <= i_lo_n;
						state_q <= ST_OUT;
					end
				end
				ST_NUM_MUL: begin
					state_q <= ST_NUM_ACC;
				end
				ST_NUM_ACC: begin
					if (kc_q == '0) begin
						kc_q    <= CW'(NCH - 1);
						state_q <= ST_DEN_MUL;
					end else begin
						kc_q    <= kc_q - 1'b1;
						state_q <= ST_NUM_MUL;
					end
				end
				ST_DEN_MUL: begin
					state_q <= ST_DEN_ACC;
				end
				ST_DEN_ACC: begin
					if (kc_q == '0) begin
						state_q <= ST_DIV_GO;
					end else begin
						kc_q    <= kc_q - 1'b1;
						state_q <= ST_DEN_MUL;
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_EST;
					end
				end
				ST_EST: begin
					held_sat_q   <= est_pct;
					held_valid_q <= 1'b1;
					state_q      <= ST_OUT;
				end
				ST_OUT: begin
					// hold here until the output register is free
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			tr_q <= {red_ext[SAMPLE_BITS-1:0], {FRACTION_BITS{1'b0}}};
			ti_q <= {ir_ext[SAMPLE_BITS-1:0], {FRACTION_BITS{1'b0}}};
		end

		if (state_q == ST_ENV) begin
			rpp_q <= rpp_c;
			ipp_q <= ipp_c;
			bsh_q <= BSH_W'(ir_base_q);
			acc_q <= '0;
		end

		if (state_q == ST_NUM_ACC) begin
			if (kc_q == '0) begin
				num_q <= acc_n;
				acc_q <= '0;
				bsh_q <= BSH_W'(red_base_q);
			end else begin
				acc_q <= acc_n;
				bsh_q <= bsh_q << GAIN_BITS;
			end
		end

		if (state_q == ST_DEN_ACC) begin
			acc_q <= acc_n;
			bsh_q <= bsh_q << GAIN_BITS;
		end

		if (out_load) begin
			sat_out_q    <= held_sat_q;
			est_out_q    <= held_valid_q;
			closed_out_q <= close_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign saturation_percent = sat_out_q;
	assign estimate_valid     = est_out_q;
	assign window_closed      = closed_out_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |=> held_valid_q)
		else $error("held estimate valid flag dropped");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EST) |-> (est_pct <= SAT_BITS'(SAT_MAX)))
		else $error("saturation estimate above 100");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_GO) |-> !div_st.busy)
		else $error("divider busy at start");

	a_env_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENV && win_end) |=>
		(r_hi_q == ENV_MIN && i_lo_q == ENV_MAX && cnt_q == '0))
		else $error("envelopes not rearmed at window close");

endmodule

// ===== sim/tb_pulse_oximetry_ratio_estimator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pulse_oximetry_ratio_estimator: a directed table, then random
// pulse-shaped bursts and noise checked against a cycle-free predictor. Needs rtl/por_pkg.sv and the RTL.
module tb_pulse_oximetry_ratio_estimator;
	import por_pkg::*;

	localparam int SB = SAMPLE_BITS_DEF;
	localparam int FB = FRACTION_BITS_DEF;
	localparam int DC_BITS = SB + FB;
	localparam longint ONE = longint'(1) << FB;
	localparam int CLK_HALF = 4;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 175;
	localparam int SETTLE_CYCLES = 60;
	localparam longint LIMIT_NS = 64'd8_000_000;
	localparam int IDLE_HEAVY = 70;
	localparam int IDLE_LIGHT = 9;
	localparam int PICK_RANDOM = -1;
	localparam int MAX_REPORTS = 10;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam logic [IN_BITS-1:0] SAMPLE_MAX = '1;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

	typedef struct packed {
		logic [SAT_BITS-1:0] saturation;
		logic                estimate_ok;
		logic                closed;
	} reading_t;

	// One line of the directed table: either a register write or a sample pair,
	// with a hand-written expectation where 'typed' is set.
	typedef struct packed {
		row_kind_e                 kind;
		logic [CFG_INDEX_BITS-1:0] index;
		logic [CFG_DATA_BITS-1:0]  data;
		logic [IN_BITS-1:0]        red;
		logic [IN_BITS-1:0]        ir;
		logic                      typed;
		logic [SAT_BITS-1:0]       sat;
		logic                      ok;
		logic                      closed;
	} script_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [IN_BITS-1:0]        red_sample;
	logic [IN_BITS-1:0]        infrared_sample;
	logic                      out_valid;
	logic                      out_ready;
	logic [SAT_BITS-1:0]       saturation_percent;
	logic                      estimate_valid;
	logic                      window_closed;

	pulse_oximetry_ratio_estimator DUT (.*);

	// Predictor state, kept at the widths of the block
	logic [DC_BITS-1:0]    red_dc, ir_dc;
	logic signed [DC_BITS:0] red_peak, red_trough, ir_peak, ir_trough;
	logic [WLEN_BITS-1:0]  window_count;
	logic [SAT_BITS-1:0]   held_percent;
	logic                  held_ok;
	logic [GAIN_BITS-1:0]  model_gain;
	logic [WLEN_BITS-1:0]  model_wlen;

	reading_t expected_readings[$];
	int       mismatch_count;
	int       send_idle_pct;
	int       recv_stall_pct;

	// Directed table. Only the first row carries a typed expectation: straight after
	// reset the window is long, so nothing closes and nothing is held yet.
	script_row_t directed_script [28] = '{
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd1000, 18'd1000, 1'b1, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd262143, 18'd0, 1'b0, 7'd0, 1'b0, 1'b0},
		// zero window length: every request closes a window
		'{ROW_CFG, REG_WINDOW_LENGTH, 16'd0, 18'd0, 18'd0, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd0, 18'd262143, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd262143, 18'd262143, 1'b0, 7'd0, 1'b0, 1'b0},
		// full gain drags the red baseline to zero in two steps, then it is reseeded
		'{ROW_CFG, REG_BASELINE_GAIN, 16'd65535, 18'd0, 18'd0, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd0, 18'd5000, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd0, 18'd6000, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd40000, 18'd30000, 1'b0, 7'd0, 1'b0, 1'b0},
		// zero gain freezes the baselines
		'{ROW_CFG, REG_BASELINE_GAIN, 16'd0, 18'd0, 18'd0, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd42000, 18'd31000, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd38000, 18'd29000, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_CFG, REG_BASELINE_GAIN, 16'd3277, 18'd0, 18'd0, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_CFG, REG_WINDOW_LENGTH, 16'd1023, 18'd0, 18'd0, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd41000, 18'd30500, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd39000, 18'd29500, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd42000, 18'd31000, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd38000, 18'd29000, 1'b0, 7'd0, 1'b0, 1'b0},
		// lower the length below the running count: the next request closes at once
		'{ROW_CFG, REG_WINDOW_LENGTH, 16'd3, 18'd0, 18'd0, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd40000, 18'd30000, 1'b0, 7'd0, 1'b0, 1'b0},
		// a write to an unmapped index must change nothing
		'{ROW_CFG, REG_UNUSED, 16'hFFFF, 18'd0, 18'd0, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_CFG, REG_BASELINE_GAIN, 16'd1, 18'd0, 18'd0, 1'b0, 7'd0, 1'b0, 1'b0},
		// large red swing against a small infrared swing: ratio pinned at its limit
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd60000, 18'd30000, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd20000, 18'd30500, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd60000, 18'd29500, 1'b0, 7'd0, 1'b0, 1'b0},
		// small red swing against a large infrared swing: estimate clamped at the top
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd40000, 18'd50000, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd40100, 18'd10000, 1'b0, 7'd0, 1'b0, 1'b0},
		'{ROW_ITEM, REG_BASELINE_GAIN, 16'd0, 18'd39900, 18'd50000, 1'b0, 7'd0, 1'b0, 1'b0}
	};

	// Random phases: register settings (PICK_RANDOM draws a fresh value)
	int phase_gain [PHASES] = '{3277, 65535, 0, PICK_RANDOM, 1, PICK_RANDOM, 65535, PICK_RANDOM};
	int phase_wlen [PHASES] = '{8, 1023, 2, 0, PICK_RANDOM, 1, PICK_RANDOM, 16};

	always #(CLK_HALF) clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	task automatic clear_envelopes();
		red_peak   = {1'b1, {DC_BITS{1'b0}}};
		red_trough = {1'b0, {DC_BITS{1'b1}}};
		ir_peak    = {1'b1, {DC_BITS{1'b0}}};
		ir_trough  = {1'b0, {DC_BITS{1'b1}}};
	endtask

	task automatic clear_prediction();
		red_dc       = '0;
		ir_dc        = '0;
		clear_envelopes();
		window_count = '0;
		held_percent = '0;
		held_ok      = 1'b0;
		model_gain   = GAIN_RESET;
		model_wlen   = WLEN_RESET;
	endtask

	// One IIR step towards the target; the fraction is floored, so a falling
	// baseline moves by the rounded-up magnitude.
	function automatic logic [DC_BITS-1:0] follow_dc(input logic [DC_BITS-1:0] level,
			input logic [DC_BITS-1:0] target, input logic [GAIN_BITS-1:0] gain);
		longint lv, tg, g, d, mag, step_sz;
		lv = level;
		tg = target;
		g = gain;
		d = tg - lv;
		mag = (d < 0) ? -d : d;
		step_sz = mag * g;
		if (d >= 0)
			return DC_BITS'(lv + (step_sz >>> GAIN_BITS));
		return DC_BITS'(lv - ((step_sz + ((longint'(1) << GAIN_BITS) - 1)) >>> GAIN_BITS));
	endfunction

	task automatic predict_reading(input logic [IN_BITS-1:0] red, input logic [IN_BITS-1:0] ir,
			output reading_t res);
		logic [DC_BITS-1:0] red_t, ir_t;
		longint rt, it, rd, id, red_ac, ir_ac, red_pp, ir_pp, ratio, level;
		logic [127:0] num, den;
		logic closed;
		red_t = {red[SB-1:0], {FB{1'b0}}};
		ir_t  = {ir[SB-1:0], {FB{1'b0}}};
		// seed both baselines while the red one is empty
		if (red_dc == '0) begin
			red_dc = red_t;
			ir_dc  = ir_t;
		end else begin
			red_dc = follow_dc(red_dc, red_t, model_gain);
			ir_dc  = follow_dc(ir_dc, ir_t, model_gain);
		end
		rt = red_t;
		it = ir_t;
		rd = red_dc;
		id = ir_dc;
		red_ac = rt - rd;
		ir_ac  = it - id;
		if (red_ac > red_peak)   red_peak   = red_ac[DC_BITS:0];
		if (red_ac < red_trough) red_trough = red_ac[DC_BITS:0];
		if (ir_ac > ir_peak)     ir_peak    = ir_ac[DC_BITS:0];
		if (ir_ac < ir_trough)   ir_trough  = ir_ac[DC_BITS:0];

		window_count = window_count + 1'b1;
		closed = (window_count >= model_wlen);
		if (closed) begin
			red_pp = red_peak - red_trough;
			ir_pp  = ir_peak - ir_trough;
			if (red_pp < 0)
				red_pp = 0;
			// a rejected window keeps the held estimate
			if (rd > ONE && id > ONE && ir_pp > ONE) begin
				num = red_pp;
				num = num * ir_dc;
				den = ir_pp;
				den = den * red_dc;
				if (num >= (den << 3))
					ratio = longint'(R_LIMIT) << FB;
				else
					ratio = longint'((num << FB) / den);
				level = SAT_OFFSET * ONE - SAT_SLOPE * ratio;
				if (level > SAT_MAX * ONE) level = SAT_MAX * ONE;
				if (level < 0) level = 0;
				held_percent = SAT_BITS'((level + (ONE >>> 1)) >>> FB);
				held_ok = 1'b1;
			end
			clear_envelopes();
			window_count = '0;
		end
		res = '{held_percent, held_ok, closed};
	endtask

	// ------------------------------------------------------------------
	// Drivers. The sample and register tasks return at the edge of their own handshake,
	// with their valid still high; whatever runs next lowers or reloads it in that step.
	// ------------------------------------------------------------------
	task automatic send_sample(input logic [IN_BITS-1:0] red, input logic [IN_BITS-1:0] ir,
			input logic typed, input reading_t typed_reading);
		reading_t predicted;
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		red_sample      <= red;
		infrared_sample <= ir;
		do @(posedge clk); while (!in_ready);
		predict_reading(red, ir, predicted);
		expected_readings.push_back(typed ? typed_reading : predicted);
	endtask

	// Hold off new requests until every expected reading is out
	task automatic wait_for_readings();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_readings.size() != 0);
	endtask

	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
			input logic [CFG_DATA_BITS-1:0] data);
		in_valid <= 1'b0;
		// registers move only while the block is idle
		while (expected_readings.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			REG_BASELINE_GAIN: model_gain = data;
			REG_WINDOW_LENGTH: model_wlen = data[WLEN_BITS-1:0];
			default: ;
		endcase
	endtask

	// Triangle pulse around a DC level with a little noise, clipped to the sample range
	function automatic logic [IN_BITS-1:0] pulse_level(input int dc, input int amp,
			input int k, input int period);
		int half, pos, level;
		half = period / 2;
		pos = k % period;
		if (pos > half)
			pos = period - pos;
		level = dc - amp / 2 + (amp * pos) / half + int'($urandom_range(15)) - 8;
		if (level < 0)
			level = 0;
		if (level > int'(SAMPLE_MAX))
			level = int'(SAMPLE_MAX);
		return IN_BITS'(level);
	endfunction

	// ------------------------------------------------------------------
	// Receiver and checker
	// ------------------------------------------------------------------
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic note_mismatch(input string what, input reading_t want, input reading_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t ns: %s: expected sat=%0d ok=%0b closed=%0b, got sat=%0d ok=%0b closed=%0b",
				$time, what, want.saturation, want.estimate_ok, want.closed,
				got.saturation, got.estimate_ok, got.closed);
	endtask

	// Sample the output handshake on the falling edge: the block only moves on the
	// rising edge, so these are the values the next rising edge accepts, and the
	// store is already up to date when the drivers look at it on that edge.
	always @(negedge clk) begin
		reading_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{saturation_percent, estimate_valid, window_closed};
			if (expected_readings.size() == 0) begin
				note_mismatch("reading with nothing outstanding", '0, got);
			end else begin
				want = expected_readings.pop_front();
				if (got.saturation !== want.saturation || got.estimate_ok !== want.estimate_ok
						|| got.closed !== want.closed)
					note_mismatch("reading mismatch", want, got);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int dc_red, dc_ir, amp_red, amp_ir, period, burst, sent;
		logic [CFG_DATA_BITS-1:0] gain_pick, wlen_pick;
		logic [IN_BITS-1:0] red_pick, ir_pick;

		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = REG_BASELINE_GAIN;
		cfg_data        = '0;
		in_valid        = 1'b0;
		red_sample      = '0;
		infrared_sample = '0;
		out_ready       = 1'b0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		mismatch_count  = 0;
		clear_prediction();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table, at full rate on both sides
		foreach (directed_script[n]) begin
			if (directed_script[n].kind == ROW_CFG)
				write_register(directed_script[n].index, directed_script[n].data);
			else
				send_sample(directed_script[n].red, directed_script[n].ir, directed_script[n].typed,
					'{directed_script[n].sat, directed_script[n].ok, directed_script[n].closed});
		end

		// Random phases: each sets both registers, then mostly pulse-shaped bursts
		// (so windows really produce estimates) with some raw noise in between
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;          recv_stall_pct = 0;          end
				1: begin send_idle_pct = IDLE_HEAVY; recv_stall_pct = 0;          end
				2: begin send_idle_pct = 0;          recv_stall_pct = IDLE_HEAVY; end
				default: begin send_idle_pct = IDLE_LIGHT; recv_stall_pct = IDLE_LIGHT; end
			endcase
			gain_pick = (phase_gain[ph] == PICK_RANDOM) ? CFG_DATA_BITS'($urandom_range(2, 65534))
				: CFG_DATA_BITS'(phase_gain[ph]);
			wlen_pick = (phase_wlen[ph] == PICK_RANDOM) ? CFG_DATA_BITS'($urandom_range(1, 40))
				: CFG_DATA_BITS'(phase_wlen[ph]);
			write_register(REG_BASELINE_GAIN, gain_pick);
			write_register(REG_WINDOW_LENGTH, wlen_pick);

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(99) < 85) begin
					dc_red  = $urandom_range(2000, 250000);
					dc_ir   = $urandom_range(2000, 250000);
					amp_red = $urandom_range(dc_red / 4);
					amp_ir  = $urandom_range(1, dc_ir / 4);
					period  = $urandom_range(4, 48);
					burst   = $urandom_range(8, 60);
					for (int k = 0; k < burst; k++)
						send_sample(pulse_level(dc_red, amp_red, k, period),
							pulse_level(dc_ir, amp_ir, k, period), 1'b0, '0);
				end else begin
					burst = $urandom_range(1, 6);
					for (int k = 0; k < burst; k++) begin
						red_pick = IN_BITS'($urandom);
						ir_pick  = IN_BITS'($urandom);
						case ($urandom_range(3))
							0: ;
							1: begin
								red_pick = $urandom_range(1) ? SAMPLE_MAX : '0;
								ir_pick  = $urandom_range(1) ? SAMPLE_MAX : '0;
							end
							2: red_pick = '0;
							default: ir_pick = '0;
						endcase
						send_sample(red_pick, ir_pick, 1'b0, '0);
					end
				end
				sent += burst;
				// now and then, let the pipeline run dry before the next burst
				if ($urandom_range(39) == 0)
					wait_for_readings();
			end
		end

		// Drain, then give any stray reading time to show up
		in_valid <= 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#(LIMIT_NS);
		$display("timeout with %0d readings outstanding", expected_readings.size());
		$display("FAIL");
		$finish;
	end

endmodule
